@@ rtl/sorted_array_table_macros.svh @@
// Assertion macros used by the sorted array table top level.
`ifndef SORTED_ARRAY_TABLE_MACROS_SVH
`define SORTED_ARRAY_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SAT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("sorted array table check failed");

// Next-cycle implication, checked outside reset.
`define SAT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("sorted array table check failed");

`endif

@@ rtl/sat_pkg.sv @@
// Package with widths, command and status codes and cell control type.
package sat_pkg;

    localparam int CAPACITY_DEF = 128;

    localparam int CMD_W     = 3;
    localparam int KEY_W     = 32;
    localparam int IDX_IN_W  = 7;
    localparam int ST_W      = 2;
    localparam int POS_W     = 7;
    localparam int CNT_OUT_W = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LFIND  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BFIND  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic cap;   // capture compare flags against the new key
        logic ins;   // insert: open a gap at the boundary
        logic rem;   // remove: close the gap at the boundary
    } t_cell_ctl;

endpackage

@@ rtl/sat_cell.sv @@
// One table cell: holds an entry, its compare flags and its neighbor shift.
module sat_cell import sat_pkg::*; #(
    parameter int CNT_W = 8,
    parameter int INDEX = 0
) (
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [CNT_W-1:0]        i_count,
    input  logic [IDX_IN_W-1:0]     i_read_index,
    input  logic signed [KEY_W-1:0] i_left_value,
    input  logic                    i_left_lt,
    input  logic signed [KEY_W-1:0] i_right_value,
    output logic signed [KEY_W-1:0] o_value,
    output logic                    o_lt,
    output logic                    o_eq,
    output logic                    o_sel,
    output logic                    o_hit
);

    logic signed [KEY_W-1:0] r_value, n_value;
    logic                    r_lt, n_lt;
    logic                    r_eq, n_eq;
    logic                    r_sel, n_sel;
    logic                    w_occ;
    logic                    w_boundary;

    assign w_occ      = CNT_W'(INDEX) < i_count;
    // first cell whose entry is not below the key
    assign w_boundary = !r_lt && i_left_lt;

    // compare on capture, shift on insert or remove
    always_comb begin
        n_value = r_value;
        n_lt    = r_lt;
        n_eq    = r_eq;
        n_sel   = r_sel;
        if (i_ctl.cap) begin
            n_lt  = w_occ && (r_value < i_key);
            n_eq  = w_occ && (r_value == i_key);
            n_sel = (INDEX == int'(i_read_index));
        end
        if (i_ctl.ins && !r_lt) begin
            n_value = w_boundary ? i_key : i_left_value;
        end else if (i_ctl.rem && !r_lt) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_lt    <= n_lt;
        r_eq    <= n_eq;
        r_sel   <= n_sel;
    end

    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
    assign o_sel   = r_sel;
    assign o_hit   = w_boundary && r_eq;

endmodule

@@ rtl/sat_collect.sv @@
// Gathers per-cell hit and select flags into found, position and read data.
module sat_collect import sat_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = 7
) (
    input  logic signed [KEY_W-1:0] i_values [CAPACITY],
    input  logic [CAPACITY-1:0]     i_hit,
    input  logic [CAPACITY-1:0]     i_sel,
    output logic                    o_found,
    output logic [IDX_W-1:0]        o_position,
    output logic signed [KEY_W-1:0] o_read_value
);

    // hit and sel are each one-hot or empty, so plain OR trees suffice
    always_comb begin
        o_position   = '0;
        o_read_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_hit[i]) begin
                o_position = o_position | IDX_W'(i);
            end
            if (i_sel[i]) begin
                o_read_value = o_read_value | i_values[i];
            end
        end
    end

    assign o_found = |i_hit;

endmodule

@@ rtl/sorted_array_table.sv @@
// Sorted array table top level: a row of compare-and-shift cells plus a control sequencer.
// Insert, remove, linear find and read: the accept edge latches the compare flags in every cell,
// then, once the result register is free, the row shifts and the result is written.
// Binary find loads the search window, then makes one midpoint probe per cycle, up to
// ceil(log2(count+1)) probes, until a hit or an empty window; a waiting result stalls the row.
// Reset (synchronous, active low) clears the count and control; entries are not cleared.
module sorted_array_table import sat_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [KEY_W-1:0]  i_key_value,
    input  logic [IDX_IN_W-1:0]      i_read_index,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [ST_W-1:0]          o_status,
    output logic [POS_W-1:0]         o_position,
    output logic signed [KEY_W-1:0]  o_read_value,
    output logic [CNT_OUT_W-1:0]     o_entry_count
);

    `include "sorted_array_table_macros.svh"

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_BSR  = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [CMD_W-1:0]        r_cmd, n_cmd;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [IDX_IN_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_lo, n_lo;
    logic [CNT_W-1:0]        r_hi1, n_hi1;
    logic                    r_out_valid, n_out_valid;
    logic [ST_W-1:0]         r_status, n_status;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic signed [KEY_W-1:0] r_rd, n_rd;
    logic [CNT_OUT_W-1:0]    r_out_count, n_out_count;

    t_cell_ctl               w_ctl;
    logic signed [KEY_W-1:0] w_cell_key;
    logic signed [KEY_W-1:0] w_value [CAPACITY];
    logic [CAPACITY-1:0]     w_lt;
    logic [CAPACITY-1:0]     w_eq;
    logic [CAPACITY-1:0]     w_sel;
    logic [CAPACITY-1:0]     w_hit;
    logic                    w_found;
    logic [IDX_W-1:0]        w_lpos;
    logic signed [KEY_W-1:0] w_rdval;
    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_full;
    logic [CNT_W:0]          w_sum;
    logic [IDX_W-1:0]        w_mid;
    logic                    w_ins_step;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_full     = r_count == CNT_W'(CAPACITY);
    assign w_cell_key = (r_state == S_IDLE) ? i_key_value : r_key;

    // midpoint of lo and hi, with hi held as hi + 1
    assign w_sum = (CNT_W + 1)'(r_lo) + (CNT_W + 1)'(r_hi1) - (CNT_W + 1)'(1);
    assign w_mid = w_sum[IDX_W:1];

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_W-1:0] w_left;
        logic                    w_left_lt;
        logic signed [KEY_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_lt = 1'b1;
        end else begin : g_mid
            assign w_left    = w_value[g-1];
            assign w_left_lt = w_lt[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_value[g];
        end else begin : g_inner
            assign w_right = w_value[g+1];
        end
        sat_cell #(
            .CNT_W (CNT_W),
            .INDEX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_key         (w_cell_key),
            .i_count       (r_count),
            .i_read_index  (i_read_index),
            .i_left_value  (w_left),
            .i_left_lt     (w_left_lt),
            .i_right_value (w_right),
            .o_value       (w_value[g]),
            .o_lt          (w_lt[g]),
            .o_eq          (w_eq[g]),
            .o_sel         (w_sel[g]),
            .o_hit         (w_hit[g])
        );
    end

    sat_collect #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_collect (
        .i_values     (w_value),
        .i_hit        (w_hit),
        .i_sel        (w_sel),
        .o_found      (w_found),
        .o_position   (w_lpos),
        .o_read_value (w_rdval)
    );

    // sequencer and result register
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_idx       = r_idx;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi1       = r_hi1;
        n_status    = r_status;
        n_pos       = r_pos;
        n_rd        = r_rd;
        n_out_count = r_out_count;
        n_out_valid = r_out_valid && !i_ready;
        w_ctl       = '0;
        w_ctl.cap   = w_accept;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = i_command;
                    n_key   = i_key_value;
                    n_idx   = i_read_index;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_BFIND) begin
                    n_lo    = '0;
                    n_hi1   = r_count;
                    n_state = S_BSR;
                end else if (w_out_free) begin
                    n_status = ST_OK;
                    n_pos    = '0;
                    n_rd     = '0;
                    case (r_cmd)
                        CMD_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.ins = 1'b1;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            if (!w_found) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                w_ctl.rem = 1'b1;
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        CMD_LFIND: begin
                            if (!w_found) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_pos = POS_W'(w_lpos);
                            end
                        end
                        CMD_READ: begin
                            if (32'(r_idx) >= 32'(r_count)) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_rd = w_rdval;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_count = CNT_OUT_W'(n_count);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_BSR: begin
                if (r_lo >= r_hi1) begin
                    if (w_out_free) begin
                        n_status    = ST_NOT_FOUND;
                        n_pos       = '0;
                        n_rd        = '0;
                        n_out_count = CNT_OUT_W'(r_count);
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (w_lt[w_mid]) begin
                    n_lo = CNT_W'(w_mid) + CNT_W'(1);
                end else if (w_eq[w_mid]) begin
                    if (w_out_free) begin
                        n_status    = ST_OK;
                        n_pos       = POS_W'(w_mid);
                        n_rd        = '0;
                        n_out_count = CNT_OUT_W'(r_count);
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_hi1 = CNT_W'(w_mid);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_lo        <= n_lo;
        r_hi1       <= n_hi1;
        r_status    <= n_status;
        r_pos       <= n_pos;
        r_rd        <= n_rd;
        r_out_count <= n_out_count;
    end

    assign o_ready       = r_state == S_IDLE;
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_position    = r_pos;
    assign o_read_value  = r_rd;
    assign o_entry_count = r_out_count;

    // checks
    assign w_ins_step = (r_state == S_EXEC) && (r_cmd == CMD_INSERT) && !w_full && w_out_free;

    `SAT_ASSERT_NXT(a_ins_count, w_ins_step, r_count == $past(r_count) + CNT_W'(1))
    `SAT_ASSERT_IMP(a_bsr_window, r_state == S_BSR, r_lo <= r_hi1)
    `SAT_ASSERT_IMP(a_miss_zero, o_valid && o_status == ST_NOT_FOUND, ~|{o_position, o_read_value})
    `SAT_ASSERT_IMP(a_full_count, o_valid && o_status == ST_FULL, o_entry_count == CNT_OUT_W'(CAPACITY))

endmodule
